@@ sv/ssc_pkg.sv @@
// Package with the constants, widths and codes of the separable 3-tap convolution.
`timescale 1ns / 1ps
`default_nettype none
package ssc_pkg;
	localparam int PIXEL_BITS = 8;
	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int CNT_W      = COL_W + 1;
	localparam int WIDTH_W    = 11;
	localparam int CMP_W      = (WIDTH_W > CNT_W) ? WIDTH_W : CNT_W;
	localparam int COEF_W     = 16;
	localparam int TAPS       = 3;
	localparam int REG_IDX_W  = 3;
	localparam int LINE_W     = 2 * PIXEL_BITS;
	localparam int VPROD_W    = COEF_W + PIXEL_BITS + 1;
	localparam int VSUM_W     = VPROD_W + 2;
	localparam int HPROD_W    = VSUM_W + COEF_W;
	localparam int HSUM_W     = HPROD_W + 2;
	localparam int OUT_W      = 48;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_VC0   = 3'd0,
		REG_VC1   = 3'd1,
		REG_VC2   = 3'd2,
		REG_HC0   = 3'd3,
		REG_HC1   = 3'd4,
		REG_HC2   = 3'd5,
		REG_WIDTH = 3'd6
	} reg_idx_t;

	localparam logic signed [COEF_W-1:0] COEF_UNITY = 16'sd4096;
	localparam logic [1:0] ROWS_FULL = 2'd2;
endpackage
`default_nettype wire

@@ sv/ssc_if.sv @@
// Stream interfaces for pixel items and filtered result items.
`timescale 1ns / 1ps
`default_nettype none
interface ssc_pixel_if;
	import ssc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;
	logic                  frame_start;
	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface ssc_result_if;
	import ssc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] filtered;
	logic                    row_end;
	modport source (output valid, output filtered, output row_end, input ready);
	modport sink (input valid, input filtered, input row_end, output ready);
endinterface
`default_nettype wire

@@ sv/ssc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ssc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ sv/separable_3tap_convolution.sv @@
// Top level: causal separable 3x3 convolution over a raster pixel stream.
// Each accepted pixel item passes the states VMUL, VSUM, HMUL and OUT in order; its
// result item is registered as OUT is left, and OUT waits while the output stalls.
// The sequencer reads the shared line store RAM, writes it back, runs the vertical
// and horizontal multiply and add steps of one pixel before it takes the next.
// Reset clears position, row count, sum history and coefficients to their defaults;
// the line store RAM is not cleared, and its data are used only after a row ends.
`timescale 1ns / 1ps
`default_nettype none
module separable_3tap_convolution (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	ssc_pixel_if.sink                           pixels,
	ssc_result_if.source                        results,
	input  wire logic                           write_en,
	input  wire logic [ssc_pkg::REG_IDX_W-1:0]  write_index,
	input  wire logic [ssc_pkg::COEF_W-1:0]     write_data
);
	import ssc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VMUL,
		ST_VSUM,
		ST_HMUL,
		ST_OUT
	} state_t;

	state_t state_q;

	logic signed [COEF_W-1:0]  vc_q [TAPS];
	logic signed [COEF_W-1:0]  hc_q [TAPS];
	logic        [WIDTH_W-1:0] width_q;

	logic [COL_W-1:0] col_q;
	logic [1:0]       rows_q;

	logic signed [VSUM_W-1:0] h1_q;
	logic signed [VSUM_W-1:0] h2_q;

	logic [PIXEL_BITS-1:0] pixel_s1;
	logic [COL_W-1:0]      col_s1;
	logic [1:0]            rows_s1;
	logic                  last_s1;

	logic signed [VPROD_W-1:0] pv_s2 [TAPS];
	logic signed [VSUM_W-1:0]  vsum_s3;
	logic signed [HPROD_W-1:0] ph_s4 [TAPS];

	logic                    res_valid_q;
	logic signed [OUT_W-1:0] filtered_q;
	logic                    row_end_q;

	logic                  accept;
	logic [COL_W-1:0]      col_eff;
	logic [1:0]            rows_eff;
	logic [CMP_W-1:0]      width_raw;
	logic [CMP_W-1:0]      width_clamp;
	logic [CMP_W-1:0]      col_next;
	logic                  last;
	logic [LINE_W-1:0]     line_rdata;
	logic [PIXEL_BITS-1:0] above_raw;
	logic [PIXEL_BITS-1:0] two_above_raw;
	logic [PIXEL_BITS-1:0] above;
	logic [PIXEL_BITS-1:0] two_above;
	logic signed [VSUM_W-1:0] h1_gated;
	logic signed [VSUM_W-1:0] h2_gated;
	logic signed [HSUM_W-1:0] hsum;
	logic                  line_we;

	assign pixels.ready     = (state_q == ST_IDLE);
	assign accept           = pixels.valid && pixels.ready;
	assign results.valid    = res_valid_q;
	assign results.filtered = filtered_q;
	assign results.row_end  = row_end_q;

	always_comb begin
		col_eff  = pixels.frame_start ? '0 : col_q;
		rows_eff = pixels.frame_start ? '0 : rows_q;
		width_raw = CMP_W'(width_q);
		if (width_raw == '0) begin
			width_clamp = CMP_W'(1);
		end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
			width_clamp = CMP_W'(MAX_WIDTH);
		end else begin
			width_clamp = width_raw;
		end
		col_next = CMP_W'(col_eff) + CMP_W'(1);
		last     = (col_next >= width_clamp);
	end

	assign above_raw     = line_rdata[LINE_W-1:PIXEL_BITS];
	assign two_above_raw = line_rdata[PIXEL_BITS-1:0];
	assign above         = (rows_s1 != 2'd0) ? above_raw : '0;
	assign two_above     = (rows_s1 == ROWS_FULL) ? two_above_raw : '0;
	assign line_we       = (state_q == ST_VMUL);

	assign h1_gated = (col_s1 != '0) ? h1_q : '0;
	assign h2_gated = (col_s1 > COL_W'(1)) ? h2_q : '0;
	assign hsum = HSUM_W'(ph_s4[0]) + HSUM_W'(ph_s4[1]) + HSUM_W'(ph_s4[2]);

	ssc_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (col_s1),
		.wdata ({pixel_s1, above_raw}),
		.re    (accept),
		.raddr (col_eff),
		.rdata (line_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q[0] <= COEF_UNITY;
			vc_q[1] <= '0;
			vc_q[2] <= '0;
			hc_q[0] <= COEF_UNITY;
			hc_q[1] <= '0;
			hc_q[2] <= '0;
			width_q <= WIDTH_W'(MAX_WIDTH);
		end else if (write_en) begin
			case (reg_idx_t'(write_index))
				REG_VC0:   vc_q[0] <= write_data;
				REG_VC1:   vc_q[1] <= write_data;
				REG_VC2:   vc_q[2] <= write_data;
				REG_HC0:   hc_q[0] <= write_data;
				REG_HC1:   hc_q[1] <= write_data;
				REG_HC2:   hc_q[2] <= write_data;
				REG_WIDTH: width_q <= write_data[WIDTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			col_q       <= '0;
			rows_q      <= '0;
			h1_q        <= '0;
			h2_q        <= '0;
		end else begin
			if (state_q == ST_OUT && (!res_valid_q || results.ready)) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						col_q <= last ? '0 : col_next[COL_W-1:0];
						if (last && rows_eff != ROWS_FULL) begin
							rows_q <= rows_eff + 2'd1;
						end else begin
							rows_q <= rows_eff;
						end
						state_q <= ST_VMUL;
					end
				end
				ST_VMUL: state_q <= ST_VSUM;
				ST_VSUM: state_q <= ST_HMUL;
				ST_HMUL: begin
					h2_q    <= h1_q;
					h1_q    <= vsum_s3;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_valid_q || results.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixels.pixel;
			col_s1   <= col_eff;
			rows_s1  <= rows_eff;
			last_s1  <= last;
		end
		if (state_q == ST_VMUL) begin
			pv_s2[0] <= VPROD_W'(vc_q[0]) * $signed(VPROD_W'({1'b0, pixel_s1}));
			pv_s2[1] <= VPROD_W'(vc_q[1]) * $signed(VPROD_W'({1'b0, above}));
			pv_s2[2] <= VPROD_W'(vc_q[2]) * $signed(VPROD_W'({1'b0, two_above}));
		end
		if (state_q == ST_VSUM) begin
			vsum_s3 <= VSUM_W'(pv_s2[0]) + VSUM_W'(pv_s2[1]) + VSUM_W'(pv_s2[2]);
		end
		if (state_q == ST_HMUL) begin
			ph_s4[0] <= HPROD_W'(hc_q[0]) * HPROD_W'(vsum_s3);
			ph_s4[1] <= HPROD_W'(hc_q[1]) * HPROD_W'(h1_gated);
			ph_s4[2] <= HPROD_W'(hc_q[2]) * HPROD_W'(h2_gated);
		end
		if (state_q == ST_OUT && (!res_valid_q || results.ready)) begin
			filtered_q <= OUT_W'(hsum);
			row_end_q  <= last_s1;
		end
	end
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench that streams pixel items through the separable 3-tap convolution.
`timescale 1ns / 1ps
module testbench;
	import ssc_pkg::*;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic                  frame_start;
	} pixel_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] filtered;
		logic                    row_end;
	} result_item_t;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 10;

	logic                 clk;
	logic                 arst_n;
	logic                 write_en;
	logic [REG_IDX_W-1:0] write_index;
	logic [COEF_W-1:0]    write_data;

	ssc_pixel_if  pix_if ();
	ssc_result_if res_if ();

	separable_3tap_convolution u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixels      (pix_if),
		.results     (res_if),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data)
	);

	logic signed [COEF_W-1:0] vert_coef [TAPS];
	logic signed [COEF_W-1:0] horiz_coef [TAPS];
	logic [WIDTH_W-1:0]       image_width;
	logic [PIXEL_BITS-1:0]    line_above [MAX_WIDTH];
	logic [PIXEL_BITS-1:0]    line_two_above [MAX_WIDTH];
	int unsigned              col_pos;
	int unsigned              rows_done;
	longint                   vsum_hist [2];

	pixel_item_t  pending_pixels [$];
	result_item_t predicted_results [$];

	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_asks;
	int hold_served;
	int hold_left;
	int stall_cycles;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int unsigned active_width(logic [WIDTH_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_WIDTH)
			return MAX_WIDTH;
		return w;
	endfunction

	function automatic result_item_t filter_pixel(pixel_item_t item);
		int unsigned  c;
		longint       up1, up2, vsum, left1, left2;
		result_item_t r;
		if (item.frame_start) begin
			col_pos = 0;
			rows_done = 0;
		end
		c = col_pos;
		up1 = (rows_done >= 1) ? longint'(line_above[c]) : 0;
		up2 = (rows_done >= ROWS_FULL) ? longint'(line_two_above[c]) : 0;
		vsum = longint'(vert_coef[0]) * longint'(item.pixel)
			+ longint'(vert_coef[1]) * up1
			+ longint'(vert_coef[2]) * up2;
		left1 = (c >= 1) ? vsum_hist[0] : 0;
		left2 = (c >= 2) ? vsum_hist[1] : 0;
		r.filtered = OUT_W'(longint'(horiz_coef[0]) * vsum
			+ longint'(horiz_coef[1]) * left1
			+ longint'(horiz_coef[2]) * left2);
		line_two_above[c] = line_above[c];
		line_above[c] = item.pixel;
		vsum_hist[1] = vsum_hist[0];
		vsum_hist[0] = vsum;
		r.row_end = (c + 1 >= active_width(image_width));
		if (r.row_end) begin
			col_pos = 0;
			if (rows_done < ROWS_FULL)
				rows_done++;
		end else begin
			col_pos = c + 1;
		end
		return r;
	endfunction

	function automatic void queue_pixel(int unsigned value, bit first);
		pixel_item_t item;
		item.pixel = value[PIXEL_BITS-1:0];
		item.frame_start = first;
		pending_pixels.push_back(item);
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return COEF_UNITY;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [COEF_W-1:0] value);
		@(posedge clk);
		write_en <= 1'b1;
		write_index <= idx;
		write_data <= value;
		case (idx)
			REG_VC0: vert_coef[0] = value;
			REG_VC1: vert_coef[1] = value;
			REG_VC2: vert_coef[2] = value;
			REG_HC0: horiz_coef[0] = value;
			REG_HC1: horiz_coef[1] = value;
			REG_HC2: horiz_coef[2] = value;
			REG_WIDTH: image_width = value[WIDTH_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_setting(input logic [COEF_W-1:0] vc0, vc1, vc2, hc0, hc1, hc2, width);
		write_reg(REG_VC0, vc0);
		write_reg(REG_VC1, vc1);
		write_reg(REG_VC2, vc2);
		write_reg(REG_HC0, hc0);
		write_reg(REG_HC1, hc1);
		write_reg(REG_HC2, hc2);
		write_reg(REG_WIDTH, width);
		@(posedge clk);
		write_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_pixels.size() != 0 || pix_if.valid || predicted_results.size() != 0);
	endtask

	// A frame restarts whenever the row grows, so no unwritten line store entry is used.
	task automatic run_random_phase(input int n_items, input bit with_hold);
		logic [COEF_W-1:0] w;
		int unsigned       prev_w;
		bit                first;
		prev_w = active_width(image_width);
		case ($urandom_range(9))
			0: w = 0;
			1: w = $urandom_range(2047, MAX_WIDTH + 1);
			2: w = $urandom_range(40, 13);
			default: w = $urandom_range(12, 1);
		endcase
		load_setting(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
			pick_coef(), w);
		if (with_hold)
			hold_asks++;
		for (int i = 0; i < n_items; i++) begin
			if (i == 0)
				first = (active_width(w[WIDTH_W-1:0]) > prev_w) || ($urandom_range(1) == 1);
			else
				first = ($urandom_range(59) == 0);
			queue_pixel($urandom_range(255), first);
		end
		wait_drained();
	endtask

	always @(posedge clk) begin : pixel_drive
		pixel_item_t sent;
		pixel_item_t next_item;
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
		end else begin
			if (pix_if.valid && pix_if.ready) begin
				sent.pixel = pix_if.pixel;
				sent.frame_start = pix_if.frame_start;
				predicted_results.push_back(filter_pixel(sent));
			end
			if (!pix_if.valid || pix_if.ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_pixels.pop_front();
					pix_if.valid <= 1'b1;
					pix_if.pixel <= next_item.pixel;
					pix_if.frame_start <= next_item.frame_start;
				end else begin
					pix_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_item_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (predicted_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, expected none, got filtered %0d row_end %0b",
						$time, $signed(res_if.filtered), res_if.row_end);
				end else begin
					want = predicted_results.pop_front();
					if (res_if.filtered !== want.filtered) begin
						errors++;
						$display("%0t: filtered mismatch, expected %0d, got %0d", $time,
							$signed(want.filtered), $signed(res_if.filtered));
					end
					if (res_if.row_end !== want.row_end) begin
						errors++;
						$display("%0t: row_end mismatch, expected %0b, got %0b", $time,
							want.row_end, res_if.row_end);
					end
				end
			end
			if (hold_served != hold_asks) begin
				hold_served <= hold_asks;
				hold_left <= HOLD_CYCLES;
				res_if.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int done_items;
		int n;
		arst_n = 1'b0;
		write_en = 1'b0;
		write_index = REG_VC0;
		write_data = '0;
		pix_if.valid = 1'b0;
		pix_if.pixel = '0;
		pix_if.frame_start = 1'b0;
		res_if.ready = 1'b0;
		vert_coef = '{COEF_UNITY, 16'sd0, 16'sd0};
		horiz_coef = '{COEF_UNITY, 16'sd0, 16'sd0};
		image_width = WIDTH_W'(MAX_WIDTH);
		col_pos = 0;
		rows_done = 0;
		vsum_hist = '{0, 0};
		send_idle_pct = 19;
		recv_idle_pct = 47;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Settings left from reset, starting without a frame marker.
		queue_pixel(255, 0);
		queue_pixel(0, 0);
		queue_pixel(85, 1);
		queue_pixel(170, 0);
		wait_drained();

		// Width zero acts as one column, so every pixel ends a row.
		load_setting(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'd0);
		queue_pixel(255, 1);
		queue_pixel(255, 0);
		queue_pixel(0, 0);
		queue_pixel(255, 0);
		queue_pixel(255, 0);
		wait_drained();

		// Most negative taps over two full rows and one more pixel, then a new frame in mid-row.
		load_setting(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd3);
		for (int i = 0; i < 7; i++)
			queue_pixel(255, i == 0);
		queue_pixel(255, 1);
		queue_pixel(255, 0);
		queue_pixel(0, 0);
		wait_drained();

		// Width above the line store size is clamped to it.
		load_setting(COEF_UNITY, 16'hf000, 16'h0800, COEF_UNITY, 16'h0800, 16'hfc00, 16'd2047);
		queue_pixel(255, 1);
		queue_pixel(0, 0);
		queue_pixel(200, 0);
		wait_drained();

		// Width lowered below the current column ends the row at once.
		load_setting(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd2);
		for (int i = 0; i < 4; i++)
			queue_pixel(255, 0);
		wait_drained();

		done_items = 0;
		while (done_items < 135) begin
			n = $urandom_range(50, 20);
			run_random_phase(n, 0);
			done_items += n;
		end
		send_idle_pct = 47;
		recv_idle_pct = 19;
		while (done_items < 270) begin
			n = $urandom_range(50, 20);
			run_random_phase(n, 0);
			done_items += n;
		end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_phase(60, 1);
		done_items += 60;
		while (done_items < 400) begin
			n = $urandom_range(50, 20);
			run_random_phase(n, 0);
			done_items += n;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && predicted_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

@@ sim.f @@
sv/ssc_pkg.sv
sv/ssc_if.sv
sv/ssc_ram.sv
sv/separable_3tap_convolution.sv
tb/sv/testbench.sv
